// File: design/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the stream substring replacer
// Payload structs, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 4;
   localparam int CNT_W           = $clog2(MAX_PATTERN + 1);
   localparam int POS_W           = $clog2(MAX_PATTERN);
   localparam int RIDX_W          = $clog2(MAX_REPLACEMENT);
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_EVERY      = 3'd4;

   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0]     pattern_type;
   typedef logic [MAX_REPLACEMENT-1:0][BYTE_W-1:0] replacement_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_has_byte;
      logic              in_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_has_byte;
      logic              out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic emit;
      logic emit_repl;
      logic drop_one;
      logic drop_pat;
      logic idx_clr;
      logic idx_inc;
      logic set_replaced;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic pend_empty;
      logic prefix_hold;
      logic full_match;
      logic repl_empty;
      logic repl_last;
      logic can_push;
      logic out_free;
      logic end_flag;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/stream_substring_replace.sv
// ----------------------------------------------------------------------------
// stream_substring_replace: streaming find-and-replace of a byte pattern
// Replaces leftmost non-overlapping occurrences (or only the first, per mode) of a pattern in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per transaction (in_has_byte qualifies the
//   byte, in_end closes the string). rsp_* carries result bytes; out_last
//   marks the final result of a string, which is a bare marker when the end
//   produces nothing else. Both channels are valid/ready.
//   csr_* writes the pattern, replacement, lengths and mode; write only while
//   the block is idle. Any write to a defined register drops held bytes.
//   One transaction at a time: a byte that produces no result passes through
//   accept, scan and finish; each result byte and each match (whether or not
//   its replacement is empty) is handled in the scan or replacement state,
//   and an end transaction also passes through the flush, one held byte at a
//   time. The sequencer and its single result port set this order.
//   Results leave through a one-entry staging register and an output
//   register; the last result of a transaction appears when the transaction
//   finishes. If rsp_ready is low the sequencer holds until space frees up.
//   Reset (synchronous, active high) clears held bytes, the mode state and
//   the output; replace_every resets to 1, all other configuration registers to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stream_substring_replace (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  ssr_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output ssr_pkg::rsp_payload_type             rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [ssr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [ssr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ssr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// File: design/ssr_ctrl.sv
// ----------------------------------------------------------------------------
// ssr_ctrl: sequencer for the stream substring replacer
// Steps the datapath through accept, scan, replacement output, flush, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssr_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  ssr_pkg::dp_status_type     status,
   output ssr_pkg::dp_cmd_type        cmd
);
   import ssr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_REPL   = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINISH = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.pend_empty || status.prefix_hold) begin
               state_in = status.end_flag ? ST_FLUSH : ST_FINISH;
            end else if (status.full_match) begin
               if (status.repl_empty) begin
                  cmd.drop_pat     = 1'b1;
                  cmd.set_replaced = 1'b1;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_REPL;
               end
            end else if (status.can_push) begin
               cmd.emit     = 1'b1;
               cmd.drop_one = 1'b1;
            end
         end
         ST_REPL: begin
            if (status.can_push) begin
               cmd.emit      = 1'b1;
               cmd.emit_repl = 1'b1;
               cmd.idx_inc   = 1'b1;
               if (status.repl_last) begin
                  cmd.drop_pat     = 1'b1;
                  cmd.set_replaced = 1'b1;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            if (status.pend_empty) begin
               state_in = ST_FINISH;
            end else if (status.can_push) begin
               cmd.emit     = 1'b1;
               cmd.drop_one = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ssr_dp.sv
// ----------------------------------------------------------------------------
// ssr_dp: datapath of the stream substring replacer
// Configuration registers, held-byte shift buffer, pattern compare,
// one-result staging register and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssr_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  ssr_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output ssr_pkg::rsp_payload_type             rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [ssr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [ssr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  ssr_pkg::dp_cmd_type                  cmd,
   output ssr_pkg::dp_status_type               status
);
   import ssr_pkg::*;

   pattern_type       pattern_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   replacement_type   repl_ff;
   logic [LEN_W-1:0]  repl_len_ff;
   logic              every_ff;

   logic [BYTE_W-1:0] pend_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] pend_in [MAX_PATTERN];
   logic [CNT_W-1:0]  pend_cnt_ff;
   logic [CNT_W-1:0]  pend_cnt_in;
   logic              replaced_ff;
   logic              replaced_in;
   logic              end_ff;
   logic              end_in;
   logic [RIDX_W-1:0] repl_idx_ff;
   logic [RIDX_W-1:0] repl_idx_in;

   logic              stg_valid_ff;
   logic              stg_valid_in;
   logic [BYTE_W-1:0] stg_byte_ff;
   logic [BYTE_W-1:0] stg_byte_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_payload_type   out_ff;
   rsp_payload_type   out_in;

   logic [LEN_W-1:0]       plen;
   logic [LEN_W-1:0]       rlen;
   logic                   active;
   logic [MAX_PATTERN-1:0] eq;
   logic                   agree_full;
   logic                   agree_prefix;
   logic [CNT_W-1:0]       drop_amt;
   logic [LEN_W-1:0]       sh;
   logic [BYTE_W-1:0]      emit_byte;
   logic                   out_free;
   logic                   can_push;
   logic                   csr_hit;

   assign plen = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_ff;
   assign rlen = (repl_len_ff > LEN_W'(MAX_REPLACEMENT)) ?
                 LEN_W'(MAX_REPLACEMENT) : repl_len_ff;
   assign active = (plen != '0) && (every_ff || !replaced_ff);

   always_comb begin
      agree_full   = 1'b1;
      agree_prefix = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         eq[i] = (pend_ff[i] == pattern_ff[i]);
         if ((LEN_W'(i) < plen) && !eq[i]) begin
            agree_full = 1'b0;
         end
         if ((CNT_W'(i) < pend_cnt_ff) && !eq[i]) begin
            agree_prefix = 1'b0;
         end
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign can_push  = !stg_valid_ff || out_free;
   assign emit_byte = cmd.emit_repl ? repl_ff[repl_idx_ff] : pend_ff[0];
   assign csr_hit   = csr_wr_en && (csr_index <= CSR_REPLACE_EVERY);

   always_comb begin
      status.pend_empty  = (pend_cnt_ff == '0);
      status.prefix_hold = active && (LEN_W'(pend_cnt_ff) < plen) && agree_prefix;
      status.full_match  = active && (LEN_W'(pend_cnt_ff) >= plen) && agree_full;
      status.repl_empty  = (rlen == '0);
      status.repl_last   = (LEN_W'(repl_idx_ff) + LEN_W'(1)) == rlen;
      status.can_push    = can_push;
      status.out_free    = out_free;
      status.end_flag    = end_ff;
   end

   // held-byte buffer: drop from the front, append at the back
   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      drop_amt    = cmd.drop_pat ? CNT_W'(plen) : CNT_W'(1);
      sh          = '0;
      if (cmd.drop_one || cmd.drop_pat) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            sh = LEN_W'(i) + LEN_W'(drop_amt);
            if (sh < LEN_W'(MAX_PATTERN)) begin
               pend_in[i] = pend_ff[sh[POS_W-1:0]];
            end
         end
         pend_cnt_in = (drop_amt >= pend_cnt_ff) ? '0 : pend_cnt_ff - drop_amt;
      end
      if (cmd.accept && req_data.in_has_byte && (pend_cnt_ff < CNT_W'(MAX_PATTERN))) begin
         pend_in[pend_cnt_ff[POS_W-1:0]] = req_data.in_byte;
         pend_cnt_in                     = pend_cnt_ff + CNT_W'(1);
      end
      if (cmd.finish && end_ff) begin
         pend_cnt_in = '0;
      end
      if (csr_hit) begin
         pend_cnt_in = '0;
      end
   end

   always_comb begin
      replaced_in = replaced_ff;
      if (cmd.set_replaced) begin
         replaced_in = 1'b1;
      end
      if (cmd.finish && end_ff) begin
         replaced_in = 1'b0;
      end
      end_in      = cmd.accept ? req_data.in_end : end_ff;
      repl_idx_in = repl_idx_ff;
      if (cmd.idx_clr) begin
         repl_idx_in = '0;
      end else if (cmd.idx_inc) begin
         repl_idx_in = repl_idx_ff + RIDX_W'(1);
      end
   end

   // staging register holds the newest result until it is known whether it is last
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      stg_valid_in = stg_valid_ff;
      stg_byte_in  = stg_byte_ff;
      if (cmd.emit) begin
         if (stg_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = '{out_byte: stg_byte_ff, out_has_byte: 1'b1, out_last: 1'b0};
         end
         stg_valid_in = 1'b1;
         stg_byte_in  = emit_byte;
      end
      if (cmd.finish) begin
         stg_valid_in = 1'b0;
         if (end_ff) begin
            out_valid_in = 1'b1;
            if (stg_valid_ff) begin
               out_in = '{out_byte: stg_byte_ff, out_has_byte: 1'b1, out_last: 1'b1};
            end else begin
               out_in = '{out_byte: '0, out_has_byte: 1'b0, out_last: 1'b1};
            end
         end else if (stg_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = '{out_byte: stg_byte_ff, out_has_byte: 1'b1, out_last: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         pat_len_ff   <= '0;
         repl_ff      <= '0;
         repl_len_ff  <= '0;
         every_ff     <= 1'b1;
         pend_cnt_ff  <= '0;
         replaced_ff  <= 1'b0;
         end_ff       <= 1'b0;
         repl_idx_ff  <= '0;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PATTERN_BYTES:      pattern_ff  <= csr_wdata;
               CSR_PATTERN_LENGTH:     pat_len_ff  <= csr_wdata[LEN_W-1:0];
               CSR_REPLACEMENT_BYTES:  repl_ff     <= csr_wdata;
               CSR_REPLACEMENT_LENGTH: repl_len_ff <= csr_wdata[LEN_W-1:0];
               CSR_REPLACE_EVERY:      every_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         pend_cnt_ff  <= pend_cnt_in;
         replaced_ff  <= replaced_in;
         end_ff       <= end_in;
         repl_idx_ff  <= repl_idx_in;
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      stg_byte_ff <= stg_byte_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= CNT_W'(MAX_PATTERN))
      else $error("held byte count above pattern capacity");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> can_push)
      else $error("result produced with staging and output both full");

   assert property (@(posedge clock) disable iff (reset)
      cmd.drop_pat |-> (plen != '0) && (LEN_W'(pend_cnt_ff) >= plen))
      else $error("pattern drop with fewer held bytes than the pattern");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && end_ff) |=> (pend_cnt_ff == '0) && !replaced_ff && out_valid_ff)
      else $error("end of string left held bytes or no final result");

endmodule

`default_nettype wire
